// File: rtl/vibe_pixel_classify_update_defines.svh
// Assertion macros for the pixel classify/update block.
`ifndef VIBE_PIXEL_CLASSIFY_UPDATE_DEFINES_SVH
`define VIBE_PIXEL_CLASSIFY_UPDATE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define VPCU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpcu assertion failed");
// Next-cycle implication.
`define VPCU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpcu assertion failed");
`else
`define VPCU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VPCU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/vpcu_pkg.sv
`default_nettype none
package vpcu_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;
    localparam int MAX_SAMPLES  = 16;

    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT * MAX_SAMPLES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int VAL_W   = 8;
    localparam int SLOT_W  = 4;
    localparam int DIR_W   = 3;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // opcodes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCHES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES     = 2'd2;

    // register reset values
    localparam logic [VAL_W-1:0] RADIUS_RST      = 8'd20;
    localparam logic [CNT_W-1:0] MIN_MATCHES_RST = 5'd2;
    localparam logic [CNT_W-1:0] SAMPLES_RST     = 5'd16;

    // neighbour directions
    localparam logic [DIR_W-1:0] DIR_TL = 3'd0;
    localparam logic [DIR_W-1:0] DIR_T  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_TR = 3'd2;
    localparam logic [DIR_W-1:0] DIR_L  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_R  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_BL = 3'd5;
    localparam logic [DIR_W-1:0] DIR_B  = 3'd6;
    localparam logic [DIR_W-1:0] DIR_BR = 3'd7;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic              opcode;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
        logic              self_update;
        logic              neighbour_update;
        logic [DIR_W-1:0]  neighbour_dir;
        logic [SLOT_W-1:0] neighbour_slot;
    } t_in;

    typedef struct packed {
        logic             foreground;
        logic [CNT_W-1:0] match_count;
    } t_out;

    function automatic t_addr addr_of(input int unsigned r, input int unsigned c,
                                      input int unsigned s);
        int unsigned a;
        a = (r * FRAME_WIDTH + c) * MAX_SAMPLES + s;
        return ADDR_W'(a);
    endfunction

    function automatic logic signed [1:0] dir_drow(input logic [DIR_W-1:0] d);
        logic signed [1:0] v;
        unique case (d)
            DIR_TL, DIR_T, DIR_TR: v = -2'sd1;
            DIR_L, DIR_R:          v = 2'sd0;
            default:               v = 2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dcol(input logic [DIR_W-1:0] d);
        logic signed [1:0] v;
        unique case (d)
            DIR_TL, DIR_L, DIR_BL: v = -2'sd1;
            DIR_T, DIR_B:          v = 2'sd0;
            default:               v = 2'sd1;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/vpcu_sample_ram.sv
`default_nettype none
module vpcu_sample_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [ADDR_W-1:0] i_waddr,
    input  wire [DATA_W-1:0] i_wdata,
    input  wire [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/vibe_pixel_classify_update.sv
// Per-pixel background model (8-bit luma samples) with classify and update.
// Input channel (i_in_valid / o_in_stall / i_in_data): a load transaction
// writes one sample of one pixel; a classify transaction compares the luma
// with the pixel's samples in slot order and, when background, may replace
// one own sample and one sample of an 8-neighbour.
// Output channel (o_out_valid / i_out_stall / o_out_data): one transaction
// per in-frame classify; loads and out-of-frame classifies give none.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// radius, min_matches, samples_in_use; always ready, write only when idle.
// Sequence: a load is written to the sample RAM as it is accepted. A classify
// is accepted, then issues its sample reads back to back (the sample RAM has a
// registered read port) until min_matches is met or all samples in use are
// read, then does the own and the neighbour write-back and parks the result.
// The next transaction is accepted while the result still waits in the
// output register; a stalled receiver only holds the block in its result
// cycle if the register is still full.
// Reset (synchronous, active low) clears control and loads register
// defaults; sample contents are undefined until loaded.
`default_nettype none
`include "vibe_pixel_classify_update_defines.svh"
module vibe_pixel_classify_update (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire vpcu_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output vpcu_pkg::t_out                       o_out_data,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [vpcu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [vpcu_pkg::CFG_DAT_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,    // stream sample reads, count matches
        S_SELF,    // own-sample replacement
        S_NBR,     // neighbour-sample replacement
        S_RESULT   // park result in output register
    } t_state;

    t_state r_state, n_state;
    vpcu_pkg::t_in  r_item, n_item;
    vpcu_pkg::t_out r_out, n_out;
    logic r_out_valid, n_out_valid;
    logic [vpcu_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [vpcu_pkg::CNT_W-1:0] r_iss, n_iss;   // next sample index to read
    logic [vpcu_pkg::CNT_W-1:0] r_lim, n_lim;   // samples to compare
    logic r_pend, n_pend;                       // read data arrives this cycle
    logic [vpcu_pkg::VAL_W-1:0] r_radius, n_radius;
    logic [vpcu_pkg::CNT_W-1:0] r_min, n_min;
    logic [vpcu_pkg::CNT_W-1:0] r_samples, n_samples;

    // sample RAM port
    logic                        ram_we;
    vpcu_pkg::t_addr             ram_waddr;
    logic [vpcu_pkg::VAL_W-1:0]  ram_wdata;
    vpcu_pkg::t_addr             ram_raddr;
    logic [vpcu_pkg::VAL_W-1:0]  ram_rdata;

    vpcu_sample_ram #(
        .DATA_W(vpcu_pkg::VAL_W),
        .DEPTH (vpcu_pkg::STORE_DEPTH),
        .ADDR_W(vpcu_pkg::ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic in_acc, cfg_acc, in_frame, bg;
    logic [vpcu_pkg::VAL_W-1:0] diff;
    logic match;
    logic [vpcu_pkg::CNT_W-1:0] cnt_sum, cur_cnt, lim_sat;
    logic signed [vpcu_pkg::ROW_W+1:0] nbr_row;
    logic signed [vpcu_pkg::COL_W+1:0] nbr_col;
    logic nbr_ok;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_frame = (32'(i_in_data.row) < vpcu_pkg::FRAME_HEIGHT)
                   && (32'(i_in_data.col) < vpcu_pkg::FRAME_WIDTH);

    assign lim_sat = (32'(r_samples) > vpcu_pkg::MAX_SAMPLES)
                   ? vpcu_pkg::CNT_W'(vpcu_pkg::MAX_SAMPLES) : r_samples;

    // match test on the sample returned this cycle
    assign diff    = (r_item.value >= ram_rdata) ? (r_item.value - ram_rdata)
                                                 : (ram_rdata - r_item.value);
    assign match   = (diff < r_radius);
    assign cnt_sum = r_cnt + vpcu_pkg::CNT_W'(match);
    assign cur_cnt = r_pend ? cnt_sum : r_cnt;
    assign bg      = (r_cnt >= r_min);

    // neighbour coordinates, signed so the top/left edge goes negative
    assign nbr_row = $signed({2'b00, r_item.row})
                   + (vpcu_pkg::ROW_W+2)'(vpcu_pkg::dir_drow(r_item.neighbour_dir));
    assign nbr_col = $signed({2'b00, r_item.col})
                   + (vpcu_pkg::COL_W+2)'(vpcu_pkg::dir_dcol(r_item.neighbour_dir));
    assign nbr_ok  = (nbr_row >= 0) && (int'(nbr_row) < vpcu_pkg::FRAME_HEIGHT)
                  && (nbr_col >= 0) && (int'(nbr_col) < vpcu_pkg::FRAME_WIDTH)
                  && (32'(r_item.neighbour_slot) < vpcu_pkg::MAX_SAMPLES);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_iss       = r_iss;
        n_lim       = r_lim;
        n_pend      = r_pend;
        n_radius    = r_radius;
        n_min       = r_min;
        n_samples   = r_samples;
        ram_we      = 1'b0;
        ram_waddr   = vpcu_pkg::addr_of(32'(i_in_data.row), 32'(i_in_data.col),
                                        32'(i_in_data.slot));
        ram_wdata   = i_in_data.value;
        ram_raddr   = vpcu_pkg::addr_of(32'(r_item.row), 32'(r_item.col), 32'(r_iss));

        if (cfg_acc) begin
            unique case (i_cfg_index)
                vpcu_pkg::CFG_RADIUS:      n_radius  = i_cfg_data;
                vpcu_pkg::CFG_MIN_MATCHES: n_min     = vpcu_pkg::CNT_W'(i_cfg_data);
                vpcu_pkg::CFG_SAMPLES:     n_samples = vpcu_pkg::CNT_W'(i_cfg_data);
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item = i_in_data;
                    if (i_in_data.opcode == vpcu_pkg::OP_LOAD) begin
                        ram_we = in_frame
                              && (32'(i_in_data.slot) < vpcu_pkg::MAX_SAMPLES);
                    end else if (in_frame) begin
                        n_state = S_SCAN;
                        n_cnt   = '0;
                        n_iss   = '0;
                        n_pend  = 1'b0;
                        n_lim   = lim_sat;
                    end
                end
            end
            S_SCAN: begin
                n_cnt = cur_cnt;
                if ((cur_cnt >= r_min) || (r_iss >= r_lim)) begin
                    n_pend  = 1'b0;
                    n_state = S_SELF;
                end else begin
                    // ram_raddr already points at r_iss
                    n_iss  = r_iss + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_SELF: begin
                ram_waddr = vpcu_pkg::addr_of(32'(r_item.row), 32'(r_item.col),
                                              32'(r_item.slot));
                ram_wdata = r_item.value;
                ram_we    = bg && r_item.self_update
                         && (32'(r_item.slot) < vpcu_pkg::MAX_SAMPLES);
                n_state   = S_NBR;
            end
            S_NBR: begin
                ram_waddr = vpcu_pkg::addr_of(32'($unsigned(nbr_row)),
                                              32'($unsigned(nbr_col)),
                                              32'(r_item.neighbour_slot));
                ram_wdata = r_item.value;
                ram_we    = bg && r_item.neighbour_update && nbr_ok;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.foreground  = !bg;
                    n_out.match_count = r_cnt;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_iss       <= '0;
            r_lim       <= '0;
            r_radius    <= vpcu_pkg::RADIUS_RST;
            r_min       <= vpcu_pkg::MIN_MATCHES_RST;
            r_samples   <= vpcu_pkg::SAMPLES_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_iss       <= n_iss;
            r_lim       <= n_lim;
            r_radius    <= n_radius;
            r_min       <= n_min;
            r_samples   <= n_samples;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    // no write-back while samples are being streamed out
    `VPCU_ASSERT_IMP(a_no_write_in_scan, i_clk, i_rst_n, r_state == S_SCAN, !ram_we)
    // matches never exceed the samples compared
    `VPCU_ASSERT_IMP(a_cnt_le_lim, i_clk, i_rst_n, r_state == S_SCAN, r_cnt <= r_lim)
    // an in-frame classify starts a scan
    `VPCU_ASSERT_NXT(a_classify_scans, i_clk, i_rst_n,
        in_acc && (i_in_data.opcode == vpcu_pkg::OP_CLASSIFY) && in_frame,
        r_state == S_SCAN)
    // finishing a classify leaves a result in the output register
    `VPCU_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n,
        (r_state == S_RESULT) && (n_state == S_IDLE), r_out_valid)

endmodule
`default_nettype wire

// File: tb/tb_vibe_pixel_classify_update.sv
`default_nettype none
module tb_vibe_pixel_classify_update;
    import vpcu_pkg::*;

    // Run sizing. The slowest classify reads all 16 samples, sender gaps and
    // receiver stalls stretch each transaction, and about 1350 transactions
    // go in.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 50;     // two slowest classifies, plus margin
    localparam int HOLD_CYCLES  = 400;    // receiver hold-off in the pressure test
    localparam int IDLE_PCT     = 21;

    // Pixels that get classified. Corners, edge midpoints and two 3x3
    // clusters, so every row and column bit takes both values and neighbour
    // writes hit the frame borders as well as other pool pixels.
    localparam int POOL_N = 26;
    int pool_row [POOL_N] = '{0, 0, 63, 63, 0, 63, 32, 31,
                              20, 20, 20, 21, 21, 21, 22, 22, 22,
                              41, 41, 41, 42, 42, 42, 43, 43, 43};
    int pool_col [POOL_N] = '{0, 63, 0, 63, 32, 31, 0, 63,
                              41, 42, 43, 41, 42, 43, 41, 42, 43,
                              20, 21, 22, 20, 21, 22, 20, 21, 22};
    int pool_luma [POOL_N];

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           item_valid = 1'b0;
    logic           item_stall;
    t_in            item_data = '0;
    logic           verdict_valid;
    logic           verdict_stall = 1'b0;
    t_out           verdict_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIUS;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // Mirror of the block: the sample store, which entries have been
    // written, and the three registers.
    logic [VAL_W-1:0] sample_bank [STORE_DEPTH];
    bit               sample_loaded [STORE_DEPTH];
    logic [VAL_W-1:0] radius_reg = RADIUS_RST;
    logic [CNT_W-1:0] min_matches_reg = MIN_MATCHES_RST;
    logic [CNT_W-1:0] samples_reg = SAMPLES_RST;

    t_out expected_verdicts [$];

    // Idle controls for both sides, plus the one-shot hold-off request.
    bit item_gaps = 1'b1;
    bit verdict_gaps = 1'b1;
    bit hold_pending = 1'b0;

    int errors = 0;
    int items_sent = 0;
    int classifies_sent = 0;
    int verdicts_seen = 0;
    int backgrounds_seen = 0;
    int cfg_writes = 0;
    int stalled_cycles = 0;

    always #6 clk = ~clk;

    vibe_pixel_classify_update u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (item_valid),
        .o_in_stall  (item_stall),
        .i_in_data   (item_data),
        .o_out_valid (verdict_valid),
        .i_out_stall (verdict_stall),
        .o_out_data  (verdict_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor: apply one accepted transaction to the mirror and queue
    // the verdict it should produce (classifies only).
    // ---------------------------------------------------------------
    task automatic predict_item(input t_in it);
        int pix_base;
        int span;
        int hits;
        int k;
        int diff;
        int nr;
        int nc;
        t_out verdict;
        pix_base = (int'(it.row) * FRAME_WIDTH + int'(it.col)) * MAX_SAMPLES;
        if (it.opcode == OP_LOAD) begin
            sample_bank[pix_base + int'(it.slot)] = it.value;
            sample_loaded[pix_base + int'(it.slot)] = 1'b1;
            return;
        end
        if (!pixel_ready(int'(it.row), int'(it.col))) begin
            $display("%0t: classify of row %0d col %0d before all samples loaded",
                     $time, it.row, it.col);
            errors++;
        end
        // samples_in_use saturates at the store's depth per pixel
        span = (int'(samples_reg) > MAX_SAMPLES) ? MAX_SAMPLES : int'(samples_reg);
        hits = 0;
        k = 0;
        // search in slot order, stop early once enough matches are in
        while (hits < int'(min_matches_reg) && k < span) begin
            diff = int'(it.value) - int'(sample_bank[pix_base + k]);
            if (diff < 0) diff = -diff;
            if (diff < int'(radius_reg)) hits++;
            k++;
        end
        verdict.match_count = CNT_W'(hits);
        if (hits >= int'(min_matches_reg)) begin
            verdict.foreground = 1'b0;
            if (it.self_update) begin
                sample_bank[pix_base + int'(it.slot)] = it.value;
                sample_loaded[pix_base + int'(it.slot)] = 1'b1;
            end
            if (it.neighbour_update) begin
                nr = int'(it.row);
                nc = int'(it.col);
                case (it.neighbour_dir)
                    DIR_TL: begin nr--; nc--; end
                    DIR_T:  nr--;
                    DIR_TR: begin nr--; nc++; end
                    DIR_L:  nc--;
                    DIR_R:  nc++;
                    DIR_BL: begin nr++; nc--; end
                    DIR_B:  nr++;
                    default: begin nr++; nc++; end
                endcase
                // neighbour off any frame border: no write
                if (nr >= 0 && nc >= 0 && nr < FRAME_HEIGHT && nc < FRAME_WIDTH) begin
                    k = (nr * FRAME_WIDTH + nc) * MAX_SAMPLES + int'(it.neighbour_slot);
                    sample_bank[k] = it.value;
                    sample_loaded[k] = 1'b1;
                end
            end
        end else begin
            verdict.foreground = 1'b1;
        end
        expected_verdicts.push_back(verdict);
    endtask

    // A classify may only target a pixel whose samples are all written.
    function automatic bit pixel_ready(input int r, input int c);
        int pix_base;
        pix_base = (r * FRAME_WIDTH + c) * MAX_SAMPLES;
        for (int s = 0; s < MAX_SAMPLES; s++)
            if (!sample_loaded[pix_base + s]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] luma_near(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[VAL_W-1:0];
    endfunction

    function automatic t_in load_item(input int r, input int c, input int s,
                                      input logic [VAL_W-1:0] v);
        t_in it;
        it = '0;
        it.opcode = OP_LOAD;
        it.row = r[ROW_W-1:0];
        it.col = c[COL_W-1:0];
        it.slot = s[SLOT_W-1:0];
        it.value = v;
        return it;
    endfunction

    // Classify of a pool pixel with random update draws; mostly luma
    // close to the pixel's model, sometimes anything.
    function automatic t_in pool_classify(input int p);
        t_in it;
        it.opcode = OP_CLASSIFY;
        it.row = pool_row[p][ROW_W-1:0];
        it.col = pool_col[p][COL_W-1:0];
        it.value = ($urandom_range(99) < 75) ? luma_near(pool_luma[p], 12)
                                              : VAL_W'($urandom_range(255));
        it.slot = SLOT_W'($urandom_range(MAX_SAMPLES - 1));
        it.self_update = 1'($urandom_range(1));
        it.neighbour_update = 1'($urandom_range(1));
        it.neighbour_dir = DIR_W'($urandom_range(7));
        it.neighbour_slot = SLOT_W'($urandom_range(MAX_SAMPLES - 1));
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Input side. Valid stays up across back-to-back transactions; it is
    // only dropped for a random gap or by drain_block().
    // ---------------------------------------------------------------
    task automatic send_item(input t_in it);
        if (item_gaps && $urandom_range(99) < IDLE_PCT) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data <= it;
        @(posedge clk);
        while (item_stall) begin
            stalled_cycles++;
            @(posedge clk);
        end
        items_sent++;
        if (it.opcode == OP_CLASSIFY) classifies_sent++;
        predict_item(it);
    endtask

    task automatic send_random_item();
        int pick;
        int p;
        t_in it;
        pick = $urandom_range(99);
        p = $urandom_range(POOL_N - 1);
        if (pick < 68) begin
            it = pool_classify(p);
        end else if (pick < 88) begin
            // refresh one sample of a pool pixel
            it = load_item(pool_row[p], pool_col[p], $urandom_range(MAX_SAMPLES - 1),
                           ($urandom_range(3) == 0) ? VAL_W'($urandom_range(255))
                                                    : luma_near(pool_luma[p], 10));
        end else begin
            // stray load anywhere in the frame
            it = load_item($urandom_range(FRAME_HEIGHT - 1), $urandom_range(FRAME_WIDTH - 1),
                           $urandom_range(MAX_SAMPLES - 1), VAL_W'($urandom_range(255)));
        end
        send_item(it);
    endtask

    // Stop offering, wait for every verdict, then let any trailing load
    // or write-back finish.
    task automatic drain_block();
        item_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_DAT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS:      radius_reg = v[VAL_W-1:0];
            CFG_MIN_MATCHES: min_matches_reg = v[CNT_W-1:0];
            CFG_SAMPLES:     samples_reg = v[CNT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int radius, input int min_m, input int n_samples);
        drain_block();
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_MIN_MATCHES, min_m);
        write_reg(CFG_SAMPLES, n_samples);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Fill every sample of the pool pixels around a per-pixel luma.
    task automatic test_pool_load();
        for (int p = 0; p < POOL_N; p++) begin
            pool_luma[p] = $urandom_range(16, 239);
            for (int s = 0; s < MAX_SAMPLES; s++)
                send_item(load_item(pool_row[p], pool_col[p], s, luma_near(pool_luma[p], 8)));
        end
    endtask

    // Top-left and bottom-right corners with every neighbour direction, edge pixels
    // pointing off the frame, luma and slot extremes, with the reset registers.
    task automatic test_frame_edges();
        t_in it;
        drain_block();
        for (int corner = 0; corner < 4; corner += 3) begin
            for (int d = 0; d < 8; d++) begin
                it = pool_classify(corner);
                it.value = pool_luma[corner][VAL_W-1:0];
                it.self_update = d[0];
                it.slot = d[0] ? SLOT_W'(MAX_SAMPLES - 1) : '0;
                it.neighbour_update = 1'b1;
                it.neighbour_dir = d[DIR_W-1:0];
                it.neighbour_slot = d[0] ? '0 : SLOT_W'(MAX_SAMPLES - 1);
                send_item(it);
            end
        end
        // top-right corner and left edge midpoint, pointing outward
        it = pool_classify(1);
        it.value = pool_luma[1][VAL_W-1:0];
        it.neighbour_update = 1'b1;
        it.neighbour_dir = DIR_TR;
        send_item(it);
        it.neighbour_dir = DIR_R;
        send_item(it);
        it = pool_classify(6);
        it.value = pool_luma[6][VAL_W-1:0];
        it.neighbour_update = 1'b1;
        it.neighbour_dir = DIR_BL;
        send_item(it);
        it.neighbour_dir = DIR_L;
        send_item(it);
        // luma extremes
        it = pool_classify(7);
        it.value = '0;
        send_item(it);
        it.value = '1;
        send_item(it);
        // load extremes: top slot with full scale, slot zero with zero
        send_item(load_item(FRAME_HEIGHT - 1, FRAME_WIDTH - 1, MAX_SAMPLES - 1, '1));
        send_item(load_item(0, 0, 0, '0));
    endtask

    // Register corners: radius zero and full scale, min_matches zero and
    // above the samples compared, samples_in_use zero and saturating.
    task automatic test_register_extremes();
        int plan [7][3] = '{'{0, 1, 16}, '{255, 16, 16}, '{20, 0, 5}, '{20, 1, 0},
                            '{40, 31, 31}, '{1, 1, 1}, '{30, 16, 4}};
        for (int ph = 0; ph < 7; ph++) begin
            apply_settings(plan[ph][0], plan[ph][1], plan[ph][2]);
            repeat (12) send_random_item();
        end
    endtask

    // Back-to-back traffic, neither side idling.
    task automatic test_burst();
        apply_settings(24, 2, 16);
        item_gaps = 1'b0;
        verdict_gaps = 1'b0;
        repeat (120) send_random_item();
        item_gaps = 1'b1;
        verdict_gaps = 1'b1;
    endtask

    // Receiver holds off for a long stretch while classifies keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_output_hold();
        drain_block();
        item_gaps = 1'b0;
        hold_pending = 1'b1;
        repeat (80) send_item(pool_classify($urandom_range(POOL_N - 1)));
        item_gaps = 1'b1;
    endtask

    // Bulk random traffic over a series of register settings.
    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            apply_settings($urandom_range(4, 48),
                           (ph % 3 == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4),
                           $urandom_range(1, 16));
            repeat (78) send_random_item();
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver stall: random, or held for HOLD_CYCLES on request.
    // ---------------------------------------------------------------
    initial begin : verdict_stall_gen
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                verdict_stall <= 1'b1;
            end else begin
                verdict_stall <= verdict_gaps && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Verdict checker: each output transaction against the oldest prediction.
    always @(posedge clk) begin
        t_out want;
        if (rst_n && verdict_valid && !verdict_stall) begin
            verdicts_seen++;
            if (!verdict_data.foreground) backgrounds_seen++;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: verdict with none expected, got fg=%0b count=%0d",
                         $time, verdict_data.foreground, verdict_data.match_count);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                if (verdict_data.foreground !== want.foreground) begin
                    $display("%0t: foreground mismatch, expected %0b, got %0b",
                             $time, want.foreground, verdict_data.foreground);
                    errors++;
                end
                if (verdict_data.match_count !== want.match_count) begin
                    $display("%0t: match_count mismatch, expected %0d, got %0d",
                             $time, want.match_count, verdict_data.match_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d verdicts outstanding",
                 cycles, expected_verdicts.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pool_load();
        test_frame_edges();
        test_register_extremes();
        test_burst();
        test_output_hold();
        test_random_phases();
        drain_block();

        if (expected_verdicts.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, expected_verdicts.size());
            errors++;
        end
        $display("covered %0d transactions (%0d classifies), %0d verdicts out, %0d background",
                 items_sent, classifies_sent, verdicts_seen, backgrounds_seen);
        $display("%0d register writes; input stalled %0d cycles under back-pressure; %0d errors",
                 cfg_writes, stalled_cycles, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
